// ===== rtl/ipv6p_pkg.sv =====
// Shared types and constants for the IPv6 text address parser.
package ipv6p_pkg;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic        ok;
		logic [63:0] addr_high;
		logic [63:0] addr_low;
		logic [7:0]  prefix_len;
	} out_item_t;

	typedef logic [7:0][15:0] words_t;

	typedef enum logic [2:0] {
		PH_GROUPS = 3'b001,
		PH_LEN    = 3'b010,
		PH_UNSPEC = 3'b100
	} phase_t;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam int         NUM_GROUPS  = 8;
	localparam logic [3:0] UNSPEC_LEN  = 4'd8;
	localparam logic [7:0] PLEN_MAX    = 8'd128;
	localparam logic [7:0] PLEN_SAT    = 8'd129;

	// Expected character at each position of "<unspec>".
	function automatic logic [7:0] unspec_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h3C;
			3'd1: c = 8'h75;
			3'd2: c = 8'h6E;
			3'd3: c = 8'h73;
			3'd4: c = 8'h70;
			3'd5: c = 8'h65;
			3'd6: c = 8'h63;
			3'd7: c = 8'h3E;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/ipv6_text_address_parser_top.sv =====
// IPv6 text address parser: one character per transfer, one result per string.
// A string's last character passes the input register, then its result is registered for the output.
// Throughput: one character per cycle; only a string's last character stalls, while a result waits on the output.
// Parse work sits between the input register and the result register.
// Reset: parse state clears, expect_prefix clears to 0, no result pending;
// group stores are not cleared.
module ipv6_text_address_parser_top
	import ipv6p_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      char_valid,
	output logic      char_ready,
	input  in_item_t  char_data,
	output logic      res_valid,
	input  logic      res_ready,
	output out_item_t res_data,
	input  logic      cfg_we,
	input  logic      cfg_wdata
);

	logic      expect_prefix_q;
	logic      valid_s1;
	in_item_t  char_s1;
	logic      res_valid_q;
	out_item_t res_q;
	out_item_t result;
	logic      out_free, step;

	assign out_free   = !res_valid_q || res_ready;
	assign step       = valid_s1 && (!char_s1.last || out_free);
	assign char_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_prefix_q <= 1'b0;
		end else if (cfg_we) begin
			expect_prefix_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid) char_s1 <= char_data;
	end

	ipv6p_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.ch            (char_s1),
		.expect_prefix (expect_prefix_q),
		.result        (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step && char_s1.last) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && char_s1.last) res_q <= result;
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

// ===== rtl/ipv6p_pack.sv =====
// Places head and tail groups into the 128-bit address, zero-filling the gap.
module ipv6p_pack
	import ipv6p_pkg::*;
(
	input  words_t      head_w,
	input  words_t      tail_w,
	input  logic [3:0]  head_cnt,
	input  logic [3:0]  tail_cnt,
	input  logic        addr_en,
	output logic [63:0] addr_high,
	output logic [63:0] addr_low
);

	words_t grp;

	always_comb begin
		for (int i = 0; i < NUM_GROUPS; i++) begin
			grp[i] = '0;
			if (addr_en) begin
				if (4'(i) < head_cnt) begin
					grp[i] = head_w[i];
				end else if ((5'(i) + {1'b0, tail_cnt}) >= 5'd8) begin
					// tail entry i + tail_cnt - 8, modulo 8
					grp[i] = tail_w[3'(i) + tail_cnt[2:0]];
				end
			end
		end
	end

	assign addr_high = {grp[0], grp[1], grp[2], grp[3]};
	assign addr_low  = {grp[4], grp[5], grp[6], grp[7]};

endmodule

// ===== rtl/ipv6p_parse.sv =====
// Per-character parse state update and end-of-string result evaluation.
module ipv6p_parse
	import ipv6p_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_item_t  ch,
	input  logic      expect_prefix,
	output out_item_t result
);

	phase_t      phase_q, a_phase;
	logic [15:0] head_q [NUM_GROUPS];
	logic [15:0] tail_q [NUM_GROUPS];
	logic [3:0]  hc_q, tc_q, a_hc, a_tc;
	logic [15:0] hex_q, a_hex;
	logic        dig_q, col_q, gap_q, fail_q;
	logic        a_dig, a_col, a_gap, a_fail;
	logic [7:0]  len_q, a_len;
	logic [3:0]  uidx_q, a_uidx;

	logic        is_hex, is_dec, may_start, slash_legal, fin_legal;
	logic [3:0]  dval;
	logic [10:0] len_prod;
	logic        push_a, push_b, push;
	logic [15:0] push_val;
	logic [4:0]  tot_q, tot_a;
	logic        ok;
	words_t      eff_head, eff_tail;
	logic [3:0]  f_hc, f_tc;
	logic [63:0] addr_high, addr_low;
	logic [7:0]  c;

	assign c = ch.char_code;

	always_comb begin
		is_hex = 1'b1;
		dval   = '0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			dval = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			dval = c[3:0] + 4'd9;  // 'a'/'A' low nibble is 1
		end else begin
			is_hex = 1'b0;
		end
	end

	assign is_dec = (c >= CH_ZERO) && (c <= CH_NINE);

	assign tot_q = {1'b0, hc_q} + {1'b0, tc_q};

	always_comb begin
		if (gap_q) begin
			may_start = ((tc_q == 4'd0 && !col_q) || (col_q && tc_q != 4'd0))
				&& (tot_q < 5'd8);
		end else begin
			may_start = (hc_q == 4'd0 && !col_q) || (col_q && hc_q != 4'd0 && hc_q < 4'd8);
		end
	end

	// address closes legally, counting a pending group
	assign slash_legal = !col_q && (gap_q ? ((tot_q + {4'd0, dig_q}) <= 5'd8)
		: ((hc_q + {3'd0, dig_q}) == 4'd8));

	assign len_prod = {len_q, 3'b000} + {2'b00, len_q, 1'b0} + {7'd0, c[3:0]};

	// handle the character
	always_comb begin
		a_phase = phase_q;
		a_hc    = hc_q;
		a_tc    = tc_q;
		a_hex   = hex_q;
		a_dig   = dig_q;
		a_col   = col_q;
		a_gap   = gap_q;
		a_len   = len_q;
		a_uidx  = uidx_q;
		a_fail  = fail_q;
		push_a  = 1'b0;
		if (!fail_q) begin
			case (phase_q)
				PH_GROUPS: begin
					if (is_hex) begin
						if (dig_q) begin
							a_hex = {hex_q[11:0], dval};
							if (hex_q[15:12] != 4'd0) a_fail = 1'b1;
						end else if (may_start) begin
							a_hex = {12'd0, dval};
							a_dig = 1'b1;
							a_col = 1'b0;
						end else begin
							a_fail = 1'b1;
						end
					end else if (c == CH_COLON) begin
						if (dig_q) begin
							push_a = 1'b1;
							a_col  = 1'b1;
						end else if (gap_q) begin
							a_fail = 1'b1;
						end else if (col_q) begin
							a_gap = 1'b1;
							a_col = 1'b0;
						end else begin
							a_col = 1'b1;
						end
					end else if (c == CH_SLASH) begin
						if (expect_prefix && slash_legal) begin
							push_a  = dig_q;
							a_phase = PH_LEN;
							a_len   = '0;
						end else begin
							a_fail = 1'b1;
						end
					end else if (c == CH_LT && !gap_q && hc_q == 4'd0 && !dig_q && !col_q) begin
						a_phase = PH_UNSPEC;
						a_uidx  = 4'd1;
					end else begin
						a_fail = 1'b1;
					end
				end
				PH_LEN: begin
					if (is_dec) begin
						a_len = (len_prod > {3'd0, PLEN_SAT}) ? PLEN_SAT : len_prod[7:0];
						a_dig = 1'b1;
					end else begin
						a_fail = 1'b1;
					end
				end
				PH_UNSPEC: begin
					if (uidx_q < UNSPEC_LEN && c == unspec_char(uidx_q[2:0])) begin
						a_uidx = uidx_q + 4'd1;
					end else begin
						a_fail = 1'b1;
					end
				end
				default: a_fail = 1'b1;
			endcase
			if (push_a) begin
				a_dig = 1'b0;
				a_hex = '0;
				if (gap_q) a_tc = tc_q + 4'd1;
				else a_hc = hc_q + 4'd1;
			end
		end
	end

	// end of string: a group still open is closed here
	assign push_b   = ch.last && !a_fail && (a_phase == PH_GROUPS) && a_dig;
	assign push     = push_a || push_b;
	assign push_val = push_a ? hex_q : a_hex;

	assign tot_a     = {1'b0, a_hc} + {1'b0, a_tc};
	assign fin_legal = !a_col && (a_gap ? ((tot_a + {4'd0, a_dig}) <= 5'd8)
		: ((a_hc + {3'd0, a_dig}) == 4'd8));

	always_comb begin
		case (a_phase)
			PH_GROUPS: ok = !expect_prefix && fin_legal;
			PH_LEN:    ok = a_dig && (a_len <= PLEN_MAX);
			PH_UNSPEC: ok = (a_uidx == UNSPEC_LEN) && !expect_prefix;
			default:   ok = 1'b0;
		endcase
		ok = ok && !a_fail;
	end

	always_comb begin
		for (int i = 0; i < NUM_GROUPS; i++) begin
			eff_head[i] = (push && !gap_q && hc_q == 4'(i)) ? push_val : head_q[i];
			eff_tail[i] = (push && gap_q && tc_q == 4'(i)) ? push_val : tail_q[i];
		end
	end

	assign f_hc = hc_q + {3'd0, push && !gap_q};
	assign f_tc = tc_q + {3'd0, push && gap_q};

	ipv6p_pack u_pack (
		.head_w    (eff_head),
		.tail_w    (eff_tail),
		.head_cnt  (f_hc),
		.tail_cnt  (f_tc),
		.addr_en   (ok && (a_phase != PH_UNSPEC)),
		.addr_high (addr_high),
		.addr_low  (addr_low)
	);

	always_comb begin
		result.ok         = ok;
		result.addr_high  = addr_high;
		result.addr_low   = addr_low;
		result.prefix_len = (ok && a_phase == PH_LEN) ? a_len : 8'd0;
	end

	// group stores: only entries written for the current string are read
	always_ff @(posedge clk) begin
		if (step && push) begin
			if (gap_q) tail_q[tc_q[2:0]] <= push_val;
			else head_q[hc_q[2:0]] <= push_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_GROUPS;
			hc_q    <= '0;
			tc_q    <= '0;
			hex_q   <= '0;
			dig_q   <= 1'b0;
			col_q   <= 1'b0;
			gap_q   <= 1'b0;
			len_q   <= '0;
			uidx_q  <= '0;
			fail_q  <= 1'b0;
		end else if (step) begin
			if (ch.last) begin
				phase_q <= PH_GROUPS;
				hc_q    <= '0;
				tc_q    <= '0;
				hex_q   <= '0;
				dig_q   <= 1'b0;
				col_q   <= 1'b0;
				gap_q   <= 1'b0;
				len_q   <= '0;
				uidx_q  <= '0;
				fail_q  <= 1'b0;
			end else begin
				phase_q <= a_phase;
				hc_q    <= a_hc;
				tc_q    <= a_tc;
				hex_q   <= a_hex;
				dig_q   <= a_dig;
				col_q   <= a_col;
				gap_q   <= a_gap;
				len_q   <= a_len;
				uidx_q  <= a_uidx;
				fail_q  <= a_fail;
			end
		end
	end

endmodule
